// ===== design/cdts_pkg.sv =====
// Shared types, codes and calendar helpers for the clock date and time setter.
`timescale 1ns / 1ps
package cdts_pkg;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  localparam logic [3:0] ST_TIME    = 4'd0;
  localparam logic [3:0] ST_TIME_MO = 4'd4;
  localparam logic [3:0] ST_DATE    = 4'd5;
  localparam logic [3:0] ST_DATE_MO = 4'd9;

  localparam logic [3:0] FLD_HOUR   = 4'd1;
  localparam logic [3:0] FLD_MINUTE = 4'd2;
  localparam logic [3:0] FLD_DAY    = 4'd3;
  localparam logic [3:0] FLD_MONTH  = 4'd4;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_MAR = 4'd3;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_MAY = 4'd5;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_AUG = 4'd8;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_OCT = 4'd10;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;

  // Reciprocal of 25 scaled by 2^17
  localparam logic [12:0] RECIP_25   = 13'd5243;
  localparam int unsigned RECIP_SHFT = 17;

  typedef struct packed {
    logic [3:0] view_mode;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [4:0] day;
    logic [3:0] month;
  } cdts_state_t;

  typedef struct packed {
    logic        mode_press;
    logic        set_press;
    logic [13:0] year;
  } cdts_event_t;

  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] prod;
    logic [9:0]  quo;
    logic [14:0] back;
    logic        by25;
    begin
      prod = y * RECIP_25;
      quo  = prod[RECIP_SHFT +: 10];
      back = quo * 5'd25;
      by25 = (back == {1'b0, y});
      return ((y[1:0] == 2'd0) && !by25) || ((y[3:0] == 4'd0) && by25);
    end
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    begin
      if (m == MON_FEB) begin
        return leap ? 5'd29 : 5'd28;
      end else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
        return 5'd30;
      end
      return 5'd31;
    end
  endfunction

endpackage

// ===== design/cdts_update.sv =====
// Next-state logic: view and set mode stepping and field increments.
`timescale 1ns / 1ps
module cdts_update import cdts_pkg::*; (
  input  cdts_state_t cur_i,
  input  cdts_event_t evt_i,
  output cdts_state_t nxt_o
);

  logic       leap;
  logic [4:0] mdays;
  logic [3:0] field;
  logic       only_mode;
  logic       only_set;

  assign leap      = is_leap(evt_i.year);
  assign mdays     = month_days(cur_i.month, leap);
  assign field     = (cur_i.view_mode < ST_DATE) ? cur_i.view_mode : cur_i.view_mode - ST_DATE;
  assign only_mode = evt_i.mode_press && !evt_i.set_press;
  assign only_set  = evt_i.set_press && !evt_i.mode_press;

  always_comb begin
    nxt_o = cur_i;
    if (cur_i.view_mode <= ST_DATE_MO) begin
      if (only_mode) begin
        if (cur_i.view_mode == ST_TIME) begin
          nxt_o.view_mode = ST_DATE;
        end else if (cur_i.view_mode == ST_DATE) begin
          nxt_o.view_mode = ST_TIME;
        end else begin
          unique case (field)
            FLD_HOUR: begin
              nxt_o.hour = (cur_i.hour >= HOUR_MAX) ? 5'd0 : cur_i.hour + 5'd1;
            end
            FLD_MINUTE: begin
              nxt_o.minute = (cur_i.minute >= MINUTE_MAX) ? 6'd0 : cur_i.minute + 6'd1;
            end
            FLD_DAY: begin
              nxt_o.day = (cur_i.day >= mdays) ? 5'd1 : cur_i.day + 5'd1;
            end
            FLD_MONTH: begin
              if (cur_i.month >= MON_DEC) begin
                nxt_o.month = MON_JAN;
              end else begin
                // Clamp the day to the month being entered
                if ((cur_i.month == MON_MAR || cur_i.month == MON_MAY ||
                     cur_i.month == MON_AUG || cur_i.month == MON_OCT) &&
                    cur_i.day >= 5'd31) begin
                  nxt_o.day = 5'd30;
                end else if (cur_i.month == MON_JAN && cur_i.day > 5'd28) begin
                  nxt_o.day = 5'd28;
                end
                nxt_o.month = cur_i.month + 4'd1;
              end
            end
            default: begin
            end
          endcase
        end
      end else if (only_set) begin
        if (cur_i.view_mode == ST_TIME_MO) begin
          nxt_o.view_mode = ST_TIME;
        end else if (cur_i.view_mode == ST_DATE_MO) begin
          nxt_o.view_mode = ST_DATE;
        end else begin
          nxt_o.view_mode = cur_i.view_mode + 4'd1;
        end
      end
    end
  end

endmodule

// ===== design/clock_date_time_setter.sv =====
// Top level of the clock date and time setter: input register, update, state register.
`timescale 1ns / 1ps
// Usage
//   Slave channel: one debounced button event per item (mode press, set press,
//   current year). Master channel: the view mode, hour, minute, day and month
//   after that event, one result item per input item.
// Timing: an accepted item sits in the input register and is applied to the
//   clock state once the master channel can take a new result; the state
//   register then offers that result on the master channel.
// Throughput: one item per cycle while m_axis_tready is high; the calendar
//   update is a single pass of logic between the input register and the state
//   register, which is also the result register.
// Reset: the state returns to time set hour, 00:00, first of January; both
//   channels empty.
// Stall: while a result waits for m_axis_tready the pending input item is
//   held and the state does not advance; s_axis_tready drops once the input
//   register is full as well, so no item is lost.
module clock_date_time_setter import cdts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] mode_press, [1] set_press, [15:2] year
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [3:0] view_mode, [8:4] hour, [14:9] minute, [19:15] day, [23:20] month
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic        in_valid_q;
  cdts_event_t evt_q;
  logic        out_valid_q;
  cdts_state_t st_q;
  cdts_state_t st_d;
  logic        advance;
  logic        take;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      evt_q.mode_press <= s_axis_tdata[0];
      evt_q.set_press  <= s_axis_tdata[1];
      evt_q.year       <= s_axis_tdata[15:2];
    end
  end

  cdts_update u_update (
    .cur_i (st_q),
    .evt_i (evt_q),
    .nxt_o (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      st_q.view_mode <= FLD_HOUR;
      st_q.hour      <= 5'd0;
      st_q.minute    <= 6'd0;
      st_q.day       <= 5'd1;
      st_q.month     <= MON_JAN;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {st_q.month, st_q.day, st_q.minute, st_q.hour, st_q.view_mode};

`ifndef SYNTHESIS
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.view_mode <= ST_DATE_MO)
    else $error("view mode out of range");

  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.hour <= HOUR_MAX && st_q.minute <= MINUTE_MAX &&
    st_q.day >= 5'd1 && st_q.day <= 5'd31 &&
    st_q.month >= MON_JAN && st_q.month <= MON_DEC)
    else $error("clock field out of range");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(st_q))
    else $error("state changed without an item");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result missing after update");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !advance)
    else $error("pending result overwritten");
`endif

endmodule
